FILE: sv/tmhq_pkg.sv
package tmhq_pkg;

	// default number of timer slots
	localparam int TIMER_SLOTS_DEF = 256;

	// free-slot search covers this many slots per cycle
	localparam int SCAN_W = 16;

	// operation codes
	typedef enum logic [2:0] {
		OP_SET_ABS = 3'd0,
		OP_SET_REL = 3'd1,
		OP_CANCEL  = 3'd2,
		OP_PROCESS = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BADH = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	// request payload
	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] time_value;
		logic [31:0] now_time;
		logic [7:0]  cancel_handle;
		logic [31:0] new_tag;
		logic [15:0] new_callback;
	} req_t;

	// result payload
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_handle;
		logic [31:0] out_tag;
		logic [15:0] out_callback;
		logic [31:0] wait_time;
		logic        fired;
	} res_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_FAIL,
		CMD_SCAN,
		CMD_INS,
		CMD_RD_PARENT,
		CMD_MOVE_UP,
		CMD_RD_CHILD,
		CMD_MOVE_DOWN,
		CMD_PLACE,
		CMD_RD_CAN,
		CMD_RD_HEAD,
		CMD_RD_TAG,
		CMD_REM,
		CMD_FINISH
	} dp_cmd_t;

	// datapath status toward the controller
	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       cancel_bad;
		logic       empty;
		logic       free_found;
		logic       pos_zero;
		logic       pos_last;
		logic       has_two;
		logic       up_less;
		logic       pick_any;
		logic       head_late;
	} dp_stat_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_FAIL,
		S_SCAN,
		S_INS,
		S_UP_RD,
		S_UP_CMP,
		S_RD_CAN,
		S_RD_HEAD,
		S_HEAD_CHK,
		S_REM,
		S_RUP_RD,
		S_RUP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_PLACE,
		S_FIN
	} state_t;

endpackage

FILE: sv/tmhq_ctrl.sv
module tmhq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tmhq_pkg::dp_stat_t stat,
	output logic               busy,
	output tmhq_pkg::dp_cmd_t  cmd
);
	import tmhq_pkg::*;

	state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_n = S_DISP;
			end
			S_DISP: begin
				if (stat.op == OP_SET_ABS || stat.op == OP_SET_REL) begin
					state_n = stat.full ? S_FAIL : S_SCAN;
				end else if (stat.op == OP_CANCEL) begin
					state_n = stat.cancel_bad ? S_FAIL : S_RD_CAN;
				end else if (stat.op == OP_PROCESS || stat.op == OP_QUERY) begin
					state_n = stat.empty ? S_FAIL : S_RD_HEAD;
				end else begin
					state_n = S_FIN;
				end
			end
			S_FAIL:   state_n = S_FIN;
			S_SCAN: begin
				if (stat.free_found) state_n = S_INS;
			end
			S_INS:    state_n = S_UP_RD;
			S_UP_RD:  state_n = stat.pos_zero ? S_PLACE : S_UP_CMP;
			S_UP_CMP: state_n = stat.up_less ? S_UP_RD : S_PLACE;
			S_RD_CAN: state_n = S_REM;
			S_RD_HEAD: state_n = S_HEAD_CHK;
			S_HEAD_CHK: begin
				if (stat.op == OP_QUERY) state_n = S_FIN;
				else if (stat.head_late) state_n = S_FAIL;
				else state_n = S_REM;
			end
			S_REM:    state_n = S_RUP_RD;
			S_RUP_RD: begin
				if (stat.pos_last) state_n = S_FIN;
				else if (stat.pos_zero) state_n = S_DN_RD;
				else state_n = S_RUP_CMP;
			end
			S_RUP_CMP: state_n = stat.up_less ? S_UP_RD : S_DN_RD;
			S_DN_RD:  state_n = stat.has_two ? S_DN_CMP : S_PLACE;
			S_DN_CMP: state_n = stat.pick_any ? S_DN_RD : S_PLACE;
			S_PLACE:  state_n = S_FIN;
			S_FIN:    state_n = S_IDLE;
			default:  state_n = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd  = CMD_NOP;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE:     if (start) cmd = CMD_LOAD;
			S_FAIL:     cmd = CMD_FAIL;
			S_SCAN:     cmd = CMD_SCAN;
			S_INS:      cmd = CMD_INS;
			S_UP_RD:    if (!stat.pos_zero) cmd = CMD_RD_PARENT;
			S_UP_CMP:   if (stat.up_less) cmd = CMD_MOVE_UP;
			S_RD_CAN:   cmd = CMD_RD_CAN;
			S_RD_HEAD:  cmd = CMD_RD_HEAD;
			S_HEAD_CHK: begin
				if (stat.op == OP_PROCESS && !stat.head_late) cmd = CMD_RD_TAG;
			end
			S_REM:      cmd = CMD_REM;
			S_RUP_RD:   if (!stat.pos_last && !stat.pos_zero) cmd = CMD_RD_PARENT;
			S_RUP_CMP:  if (stat.up_less) cmd = CMD_MOVE_UP;
			S_DN_RD:    if (stat.has_two) cmd = CMD_RD_CHILD;
			S_DN_CMP:   if (stat.pick_any) cmd = CMD_MOVE_DOWN;
			S_PLACE:    cmd = CMD_PLACE;
			S_FIN:      cmd = CMD_FINISH;
			default:    cmd = CMD_NOP;
		endcase
	end

endmodule

FILE: sv/tmhq_dp.sv
module tmhq_dp #(
	parameter int TIMER_SLOTS = tmhq_pkg::TIMER_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tmhq_pkg::req_t     request,
	input  tmhq_pkg::dp_cmd_t  cmd,
	output tmhq_pkg::dp_stat_t stat,
	output logic               done,
	output tmhq_pkg::res_t     result
);
	import tmhq_pkg::*;

	localparam int HW  = $clog2(TIMER_SLOTS);
	localparam int CNW = $clog2(TIMER_SLOTS + 1);
	localparam int PW  = HW + 2;
	localparam int NCH = (TIMER_SLOTS + SCAN_W - 1) / SCAN_W;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int UW  = NCH * SCAN_W;
	localparam int SBW = $clog2(SCAN_W);

	// control state
	logic [CNW-1:0]         count_q;
	logic [TIMER_SLOTS-1:0] use_q;
	logic [CHW-1:0]         chunk_q;
	logic                   fail_q;
	logic                   done_q;

	// working registers
	req_t        req_q;
	logic [31:0] when_q;
	logic [HW-1:0] pos_q;
	logic [31:0] mkey_q;
	logic [HW-1:0] mh_q;
	logic [31:0] rdak_q, rdbk_q;
	logic [HW-1:0] rdah_q, rdbh_q;
	logic [HW-1:0] rdp_q;
	logic [31:0] rdt_q;
	logic [15:0] rdc_q;
	logic [HW-1:0] resh_q;
	res_t        res_q;

	// heap by position (key and handle), place by handle, payload by handle
	logic [31:0]   hk_mem  [TIMER_SLOTS];
	logic [HW-1:0] hh_mem  [TIMER_SLOTS];
	logic [HW-1:0] pl_mem  [TIMER_SLOTS];
	logic [31:0]   tag_mem [TIMER_SLOTS];
	logic [15:0]   cb_mem  [TIMER_SLOTS];

	logic [UW-1:0]     use_pad;
	logic [SCAN_W-1:0] chunk_bits;
	logic              free_found;
	logic [SBW-1:0]    free_bit;
	logic [HW-1:0]     new_h;
	logic [HW-1:0]     ch_h;
	logic              ch_range_bad;
	logic [HW-1:0]     par;
	logic [PW-1:0]     c1_x, c2_x;
	logic [HW-1:0]     last_addr;
	logic              c1_less, c2_less;
	logic [31:0]       kmin;
	logic              is_proc;
	logic [HW-1:0]     rem_h;
	logic [31:0]       when_n;
	logic              hp_we;
	logic [HW-1:0]     hp_wa;
	logic [31:0]       hp_wk;
	logic [HW-1:0]     hp_wh;
	logic [HW-1:0]     a_addr, b_addr, t_addr;
	res_t              res_n;

	// free-slot search, one chunk per cycle, padding counts as used
	always_comb begin
		use_pad = '1;
		use_pad[TIMER_SLOTS-1:0] = use_q;
		chunk_bits = use_pad[chunk_q*SCAN_W +: SCAN_W];
		free_found = ~&chunk_bits;
		free_bit = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (!chunk_bits[i]) free_bit = SBW'(i);
		end
		new_h = HW'({chunk_q, free_bit});
	end

	// heap index arithmetic
	always_comb begin
		ch_h         = HW'(req_q.cancel_handle);
		ch_range_bad = ({24'd0, req_q.cancel_handle} >= 32'(TIMER_SLOTS));
		par          = (pos_q - HW'(1)) >> 1;
		c1_x         = PW'({pos_q, 1'b1});
		c2_x         = c1_x + PW'(1);
		last_addr    = HW'(count_q - CNW'(1));
		c1_less      = rdak_q < mkey_q;
		kmin         = c1_less ? rdak_q : mkey_q;
		c2_less      = rdbk_q < kmin;
		is_proc      = (req_q.opcode == OP_PROCESS);
		rem_h        = is_proc ? rdah_q : ch_h;
	end

	// status toward the controller
	always_comb begin
		stat.op         = req_q.opcode;
		stat.full       = (count_q == CNW'(TIMER_SLOTS));
		stat.cancel_bad = ch_range_bad || !use_q[ch_h];
		stat.empty      = (count_q == '0);
		stat.free_found = free_found;
		stat.pos_zero   = (pos_q == '0);
		stat.pos_last   = (CNW'(pos_q) == count_q);
		stat.has_two    = (c2_x <= PW'(count_q));
		stat.up_less    = mkey_q < rdak_q;
		stat.pick_any   = c1_less || c2_less;
		stat.head_late  = rdak_q > req_q.now_time;
	end

	// expiry of a new timer, relative sum saturates
	always_comb begin
		if (request.opcode == OP_SET_REL) begin
			when_n = (request.time_value > ~request.now_time) ? 32'hFFFF_FFFF
				: request.now_time + request.time_value;
		end else begin
			when_n = request.time_value;
		end
	end

	// heap and place write port
	always_comb begin
		hp_we = 1'b0;
		hp_wa = pos_q;
		hp_wk = mkey_q;
		hp_wh = mh_q;
		unique case (cmd)
			CMD_MOVE_UP: begin
				hp_we = 1'b1;
				hp_wk = rdak_q;
				hp_wh = rdah_q;
			end
			CMD_MOVE_DOWN: begin
				hp_we = 1'b1;
				hp_wk = c2_less ? rdbk_q : rdak_q;
				hp_wh = c2_less ? rdbh_q : rdah_q;
			end
			CMD_PLACE: hp_we = 1'b1;
			default: hp_we = 1'b0;
		endcase
	end

	// read addresses
	always_comb begin
		unique case (cmd)
			CMD_RD_PARENT: a_addr = par;
			CMD_RD_CHILD:  a_addr = HW'(c1_x);
			default:       a_addr = '0;
		endcase
		b_addr = (cmd == CMD_RD_CHILD) ? HW'(c2_x) : last_addr;
		t_addr = (cmd == CMD_RD_CAN) ? ch_h : rdah_q;
	end

	// heap memory
	always_ff @(posedge clk) begin
		if (hp_we) begin
			hk_mem[hp_wa] <= hp_wk;
			hh_mem[hp_wa] <= hp_wh;
		end
		if (cmd == CMD_RD_PARENT || cmd == CMD_RD_CHILD || cmd == CMD_RD_HEAD) begin
			rdak_q <= hk_mem[a_addr];
			rdah_q <= hh_mem[a_addr];
		end
		if (cmd == CMD_RD_CHILD || cmd == CMD_RD_HEAD || cmd == CMD_RD_CAN) begin
			rdbk_q <= hk_mem[b_addr];
			rdbh_q <= hh_mem[b_addr];
		end
	end

	// place memory
	always_ff @(posedge clk) begin
		if (hp_we) pl_mem[hp_wh] <= pos_q;
		if (cmd == CMD_RD_CAN) rdp_q <= pl_mem[ch_h];
	end

	// tag and callback memories
	always_ff @(posedge clk) begin
		if (cmd == CMD_INS) begin
			tag_mem[new_h] <= req_q.new_tag;
			cb_mem[new_h]  <= req_q.new_callback;
		end
		if (cmd == CMD_RD_CAN || cmd == CMD_RD_TAG) begin
			rdt_q <= tag_mem[t_addr];
			rdc_q <= cb_mem[t_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			use_q   <= '0;
			chunk_q <= '0;
			fail_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (cmd == CMD_FINISH);
			unique case (cmd)
				CMD_LOAD: begin
					chunk_q <= '0;
					fail_q  <= 1'b0;
				end
				CMD_SCAN: if (!free_found) chunk_q <= chunk_q + CHW'(1);
				CMD_INS: begin
					use_q[new_h] <= 1'b1;
					count_q      <= count_q + CNW'(1);
				end
				CMD_REM: begin
					use_q[rem_h] <= 1'b0;
					count_q      <= count_q - CNW'(1);
				end
				CMD_FAIL: fail_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// result assembly
	always_comb begin
		res_n = '0;
		unique case (req_q.opcode)
			OP_SET_ABS, OP_SET_REL: begin
				if (fail_q) res_n.status = ST_FULL;
				else res_n.out_handle = 8'(resh_q);
			end
			OP_CANCEL: begin
				res_n.out_handle = req_q.cancel_handle;
				if (fail_q) res_n.status = ST_BADH;
				else res_n.out_tag = rdt_q;
			end
			OP_PROCESS: begin
				if (fail_q) begin
					res_n.status = ST_NONE;
				end else begin
					res_n.out_handle   = 8'(resh_q);
					res_n.out_tag      = rdt_q;
					res_n.out_callback = rdc_q;
					res_n.fired        = 1'b1;
				end
			end
			OP_QUERY: begin
				if (fail_q) res_n.status = ST_NONE;
				else if (rdak_q > req_q.now_time) res_n.wait_time = rdak_q - req_q.now_time;
			end
			default: res_n = '0;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				req_q  <= request;
				when_q <= when_n;
			end
			CMD_INS: begin
				mkey_q <= when_q;
				mh_q   <= new_h;
				pos_q  <= HW'(count_q);
				resh_q <= new_h;
			end
			CMD_MOVE_UP: pos_q <= par;
			CMD_MOVE_DOWN: pos_q <= c2_less ? HW'(c2_x) : HW'(c1_x);
			CMD_REM: begin
				mkey_q <= rdbk_q;
				mh_q   <= rdbh_q;
				pos_q  <= is_proc ? '0 : rdp_q;
				resh_q <= rem_h;
			end
			CMD_FINISH: res_q <= res_n;
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: sv/timer_min_heap_queue_top.sv
// a set searches 16-slot chunks for a free handle, then sifts the new timer up the heap
// level by level; cancel and process remove a timer and sift the moved one up or down
// the heap; each level is a read then a write
// busy is high while a request is in progress, failed and undefined requests included
// one request at a time; the next can be accepted while its result shows on done
// reset clears slot-in-use map, timer count and control only; results cannot be stalled
module timer_min_heap_queue_top #(
	parameter int TIMER_SLOTS = tmhq_pkg::TIMER_SLOTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tmhq_pkg::req_t request,
	output logic           done,
	output tmhq_pkg::res_t result
);
	import tmhq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing
	tmhq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// heap storage and arithmetic
	tmhq_dp #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

	// result only after the controller is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");

	// an accepted transfer makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");

	// each transfer gives one result; this checks that two never come in a row
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("back to back result strobes");

	// a request is latched only by an accepted transfer
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> (start && !busy))
		else $error("request latched outside an accepted transfer");

endmodule
